### hdl/tsu8_pkg.sv
// Shared types, constants and UTF-8 helper functions of the text string transcoder.
package tsu8_pkg;

	localparam int BYTE_W  = 8;
	localparam int CP_W    = 16;
	localparam int TAB_DEPTH = 256;
	localparam int MODE_W  = 3;

	// Decoder modes.
	localparam logic [MODE_W-1:0] MODE_AWAIT  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_HOLD   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_SINGLE = 3'd2;
	localparam logic [MODE_W-1:0] MODE_BE     = 3'd3;
	localparam logic [MODE_W-1:0] MODE_LE     = 3'd4;

	// Command codes.
	localparam logic CMD_DATA  = 1'b0;
	localparam logic CMD_TABLE = 1'b1;

	// Byte order mark bytes.
	localparam logic [BYTE_W-1:0] MARK_FE = 8'hFE;
	localparam logic [BYTE_W-1:0] MARK_FF = 8'hFF;

	// One job handed from the decoder to the emitter: up to two code points
	// and an optional closing zero byte.
	typedef struct packed {
		logic [1:0]      nch;
		logic            term;
		logic [CP_W-1:0] cp0;
		logic [CP_W-1:0] cp1;
	} job_t;

	// Number of UTF-8 bytes of a 16-bit code point.
	function automatic logic [1:0] utf8_len(input logic [CP_W-1:0] cp);
		logic [1:0] len;
		if (cp[15:7] == 9'd0) begin
			len = 2'd1;
		end else if (cp[15:11] == 5'd0) begin
			len = 2'd2;
		end else begin
			len = 2'd3;
		end
		return len;
	endfunction

	// Byte number idx of the UTF-8 form of a 16-bit code point.
	function automatic logic [BYTE_W-1:0] utf8_byte(input logic [CP_W-1:0] cp,
			input logic [1:0] idx);
		logic [BYTE_W-1:0] b;
		case (utf8_len(cp))
			2'd1: begin
				b = cp[7:0];
			end
			2'd2: begin
				b = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
			end
			default: begin
				case (idx)
					2'd0:    b = {4'b1110, cp[15:12]};
					2'd1:    b = {2'b10, cp[11:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
		endcase
		return b;
	endfunction

endpackage

### hdl/tsu8_in_if.sv
// Input channel: valid/ready handshake carrying one command or string byte word.
interface tsu8_in_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [7:0]  data_byte;
	logic        end_of_string;
	logic [7:0]  table_index;
	logic [15:0] table_value;

	modport source (output valid, command, data_byte, end_of_string, table_index,
		table_value, input ready);
	modport sink (input valid, command, data_byte, end_of_string, table_index,
		table_value, output ready);
endinterface

### hdl/tsu8_out_if.sv
// Output channel: valid/ready handshake carrying one UTF-8 byte word.
interface tsu8_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       terminator;

	modport source (output valid, out_byte, run_last, terminator, input ready);
	modport sink (input valid, out_byte, run_last, terminator, output ready);
endinterface

### hdl/tsu8_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module tsu8_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port; data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hdl/tsu8_decode.sv
// String decoder: mark detection, byte pairing, code table memories and the job stage.
module tsu8_decode (
	input  logic            clk,
	input  logic            arst_n,
	tsu8_in_if.sink         din,
	output logic            job_valid,
	input  logic            job_ready,
	output tsu8_pkg::job_t  job
);

	logic [tsu8_pkg::MODE_W-1:0] mode_q, mode_d;
	logic [tsu8_pkg::BYTE_W-1:0] held_q, held_d;
	logic                        phase_q, phase_d;

	logic [1:0]                  nch_d;
	logic                        use_tab_d;
	logic [tsu8_pkg::CP_W-1:0]   unit_d;
	logic [tsu8_pkg::BYTE_W-1:0] addr_a;
	logic                        is_mark;
	logic                        push;
	logic                        in_fire;
	logic                        is_data;

	logic                        valid_s1;
	logic [1:0]                  nch_s1;
	logic                        term_s1;
	logic                        use_tab_s1;
	logic [tsu8_pkg::CP_W-1:0]   unit_s1;
	logic [tsu8_pkg::CP_W-1:0]   rd_a;
	logic [tsu8_pkg::CP_W-1:0]   rd_b;

	assign din.ready = !valid_s1 || job_ready;
	assign in_fire   = din.valid && din.ready;
	assign is_data   = (din.command == tsu8_pkg::CMD_DATA);

	assign is_mark = (held_q == tsu8_pkg::MARK_FE && din.data_byte == tsu8_pkg::MARK_FF) ||
		(held_q == tsu8_pkg::MARK_FF && din.data_byte == tsu8_pkg::MARK_FE);

	assign unit_d = (mode_q == tsu8_pkg::MODE_BE) ? {held_q, din.data_byte}
		: {din.data_byte, held_q};

	// Next decoder state and the code points this byte releases.
	always_comb begin
		mode_d    = mode_q;
		held_d    = held_q;
		phase_d   = phase_q;
		nch_d     = 2'd0;
		use_tab_d = 1'b1;
		addr_a    = din.data_byte;
		case (mode_q)
			tsu8_pkg::MODE_HOLD: begin
				if (is_mark) begin
					mode_d  = (held_q == tsu8_pkg::MARK_FE) ? tsu8_pkg::MODE_BE
						: tsu8_pkg::MODE_LE;
					phase_d = 1'b0;
				end else begin
					nch_d  = 2'd2;
					addr_a = held_q;
					mode_d = tsu8_pkg::MODE_SINGLE;
				end
			end
			tsu8_pkg::MODE_SINGLE: begin
				nch_d = 2'd1;
			end
			tsu8_pkg::MODE_BE, tsu8_pkg::MODE_LE: begin
				if (!phase_q) begin
					held_d  = din.data_byte;
					phase_d = 1'b1;
				end else begin
					nch_d     = 2'd1;
					use_tab_d = 1'b0;
					phase_d   = 1'b0;
				end
			end
			default: begin
				if ((din.data_byte == tsu8_pkg::MARK_FE || din.data_byte == tsu8_pkg::MARK_FF)
						&& !din.end_of_string) begin
					held_d = din.data_byte;
					mode_d = tsu8_pkg::MODE_HOLD;
				end else begin
					nch_d  = 2'd1;
					mode_d = tsu8_pkg::MODE_SINGLE;
				end
			end
		endcase
		if (din.end_of_string) begin
			mode_d  = tsu8_pkg::MODE_AWAIT;
			held_d  = '0;
			phase_d = 1'b0;
		end
	end

	assign push = is_data && (nch_d != 2'd0 || din.end_of_string);

	// Decoder state registers, advanced by data words only.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= tsu8_pkg::MODE_AWAIT;
			held_q  <= '0;
			phase_q <= 1'b0;
		end else if (in_fire && is_data) begin
			mode_q  <= mode_d;
			held_q  <= held_d;
			phase_q <= phase_d;
		end
	end

	// Two copies of the code table so that a non-mark byte pair reads both entries at once.
	tsu8_ram #(
		.WIDTH(tsu8_pkg::CP_W),
		.DEPTH(tsu8_pkg::TAB_DEPTH)
	) u_tab_a (
		.clk   (clk),
		.we    (in_fire && !is_data),
		.waddr (din.table_index),
		.wdata (din.table_value),
		.re    (in_fire && is_data),
		.raddr (addr_a),
		.rdata (rd_a)
	);

	tsu8_ram #(
		.WIDTH(tsu8_pkg::CP_W),
		.DEPTH(tsu8_pkg::TAB_DEPTH)
	) u_tab_b (
		.clk   (clk),
		.we    (in_fire && !is_data),
		.waddr (din.table_index),
		.wdata (din.table_value),
		.re    (in_fire && is_data),
		.raddr (din.data_byte),
		.rdata (rd_b)
	);

	// Job stage, aligned with the table read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= push;
		end else if (job_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && is_data) begin
			nch_s1     <= nch_d;
			term_s1    <= din.end_of_string;
			use_tab_s1 <= use_tab_d;
			unit_s1    <= unit_d;
		end
	end

	assign job_valid = valid_s1;
	assign job       = {nch_s1, term_s1, (use_tab_s1 ? rd_a : unit_s1), rd_b};

	// A held mark byte never coexists with half a 16-bit unit.
	a_hold_no_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == tsu8_pkg::MODE_HOLD) |-> !phase_q)
		else $error("mark byte held while a unit half is pending");

	// Pairing only happens in the 16-bit modes.
	a_phase_mode: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> (mode_q == tsu8_pkg::MODE_BE || mode_q == tsu8_pkg::MODE_LE))
		else $error("unit half pending outside a 16-bit mode");

	// A queued job always produces at least one byte.
	a_job_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (nch_s1 != 2'd0 || term_s1))
		else $error("empty job queued");

endmodule

### hdl/tsu8_emit.sv
// UTF-8 emitter: walks a job's code points byte by byte into the output register.
module tsu8_emit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            job_valid,
	output logic            job_ready,
	input  tsu8_pkg::job_t  job,
	tsu8_out_if.source      dout
);

	logic                        busy_q;
	logic [1:0]                  nch_q;
	logic                        term_q;
	logic [tsu8_pkg::CP_W-1:0]   cp0_q;
	logic [tsu8_pkg::CP_W-1:0]   cp1_q;
	logic [1:0]                  ch_q;
	logic [1:0]                  bi_q;

	logic                        ovalid_q;
	logic [tsu8_pkg::BYTE_W-1:0] obyte_q;
	logic                        olast_q;
	logic                        oterm_q;

	logic                        step;
	logic                        in_char;
	logic [tsu8_pkg::CP_W-1:0]   cur_cp;
	logic [1:0]                  cur_len;
	logic                        last_byte;
	logic [tsu8_pkg::BYTE_W-1:0] nbyte;
	logic                        nlast;
	logic                        nterm;
	logic                        done;
	logic [1:0]                  ch_nx;
	logic [1:0]                  bi_nx;

	assign step      = busy_q && (!ovalid_q || dout.ready);
	assign job_ready = !busy_q || (step && done);

	assign in_char   = (ch_q != nch_q);
	assign cur_cp    = ch_q[0] ? cp1_q : cp0_q;
	assign cur_len   = tsu8_pkg::utf8_len(cur_cp);
	assign last_byte = ((bi_q + 2'd1) == cur_len);

	// Pick the next byte and the position after it.
	always_comb begin
		nbyte = '0;
		nlast = 1'b1;
		nterm = 1'b1;
		done  = 1'b1;
		ch_nx = ch_q;
		bi_nx = bi_q;
		if (in_char) begin
			nbyte = tsu8_pkg::utf8_byte(cur_cp, bi_q);
			nterm = 1'b0;
			if (last_byte) begin
				ch_nx = ch_q + 2'd1;
				bi_nx = 2'd0;
				done  = ((ch_q + 2'd1) == nch_q) && !term_q;
			end else begin
				bi_nx = bi_q + 2'd1;
				done  = 1'b0;
			end
			nlast = done;
		end
	end

	// Job register and byte position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (job_ready) begin
			busy_q <= job_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (job_ready && job_valid) begin
			nch_q  <= job.nch;
			term_q <= job.term;
			cp0_q  <= job.cp0;
			cp1_q  <= job.cp1;
			ch_q   <= 2'd0;
			bi_q   <= 2'd0;
		end else if (step) begin
			ch_q <= ch_nx;
			bi_q <= bi_nx;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (step) begin
			ovalid_q <= 1'b1;
		end else if (dout.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			obyte_q <= nbyte;
			olast_q <= nlast;
			oterm_q <= nterm;
		end
	end

	assign dout.valid      = ovalid_q;
	assign dout.out_byte   = obyte_q;
	assign dout.run_last   = olast_q;
	assign dout.terminator = oterm_q;

	// The character index never runs past the job's character count.
	a_ch_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (ch_q <= nch_q && nch_q <= 2'd2))
		else $error("character index beyond job");

	// Once all characters are out, only the closing zero byte can remain.
	a_term_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !in_char) |-> term_q)
		else $error("job has nothing left to emit");

	// The byte index stays inside the current character.
	a_bi_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && in_char) |-> (bi_q < cur_len))
		else $error("byte index beyond UTF-8 length");

endmodule

### hdl/text_string_to_utf8_top.sv
// Top level of the text string to UTF-8 transcoder.
// Words enter on din: a table word (command 1) writes one entry of the 256-entry
// code table, a data word (command 0) carries the next string byte. A string that
// opens with FE FF or FF FE is read as big- or little-endian 16-bit units; any
// other string is mapped byte by byte through the table, which must be written
// before it is used. Each word yields 0 to 7 bytes on dout, and the last byte of
// a string is followed by a zero byte with terminator set. The emitter puts out
// one byte per cycle while dout.ready does not hold it back. While a word's bytes
// are still going out, at most two further words that yield bytes are held; table
// words and held bytes keep flowing while the job stage is free. The first byte of
// a word passes the job stage, the emitter's job register and the output register
// before it appears on dout. The table is not cleared by reset.
module text_string_to_utf8_top (
	input logic        clk,
	input logic        arst_n,
	tsu8_in_if.sink    din,
	tsu8_out_if.source dout
);

	logic           job_valid;
	logic           job_ready;
	tsu8_pkg::job_t job;

	tsu8_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.din       (din),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job)
	);

	tsu8_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job),
		.dout      (dout)
	);

endmodule
